>>> src/p2n_pkg.sv
// ----------------------------------------------------------------------------
// p2n_pkg - shared types and constants of the pitch-to-note stabilizer
// Word types, register codes, sequencer states and the semitone edge table.
// ----------------------------------------------------------------------------
package p2n_pkg;

	localparam int FREQ_FRAC_BITS = 4;
	localparam int MAX_NOTE       = 127;

	localparam int FREQ_W     = 20;
	localparam int NOTE_W     = 7;
	localparam int RAW_W      = 8;
	localparam int VEL_W      = 7;
	localparam int EDGE_W     = 26;
	localparam int LHS_SHIFT  = 22;
	// widest boundary: 26-bit edge shifted by 21 octaves plus the fraction bits
	localparam int CMP_W      = EDGE_W + 21 + FREQ_FRAC_BITS + 1;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	typedef struct packed {
		logic                 pitch_found;
		logic [15:0]          signal_level;
		logic [15:0]          pitch_confidence;
		logic [FREQ_W-1:0]    pitch_frequency;
	} in_word_t;

	typedef struct packed {
		logic                 event_kind;
		logic [NOTE_W-1:0]    note_number;
		logic [VEL_W-1:0]     event_velocity;
		logic                 last_event;
	} out_word_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GATE_THRESHOLD = 3'd0,
		REG_MIN_CONFIDENCE = 3'd1,
		REG_TRANSPOSE      = 3'd2,
		REG_NOTE_VELOCITY  = 3'd3,
		REG_HOLD_BLOCKS    = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_DECIDE
	} seq_state_t;

	localparam logic EV_NOTE_OFF = 1'b0;
	localparam logic EV_NOTE_ON  = 1'b1;

	typedef struct packed {
		logic busy;
		logic done;
	} srch_stat_t;

	// ceil(edge * 65536) of the lower boundaries of notes 69..80
	function automatic logic [EDGE_W-1:0] edge_value(input logic [3:0] idx);
		logic [EDGE_W-1:0] v;
		unique case (idx)
			4'd0:    v = 26'd28014940;
			4'd1:    v = 26'd29680795;
			4'd2:    v = 26'd31445707;
			4'd3:    v = 26'd33315566;
			4'd4:    v = 26'd35296613;
			4'd5:    v = 26'd37395458;
			4'd6:    v = 26'd39619108;
			4'd7:    v = 26'd41974983;
			4'd8:    v = 26'd44470945;
			4'd9:    v = 26'd47115325;
			4'd10:   v = 26'd49916948;
			4'd11:   v = 26'd52885164;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

>>> src/p2n_search.sv
// ----------------------------------------------------------------------------
// p2n_search - binary search for the raw note of a frequency
// One boundary compare per cycle while busy, from start until done.
// ----------------------------------------------------------------------------
module p2n_search (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [p2n_pkg::FREQ_W-1:0]   freq,
	output p2n_pkg::srch_stat_t          stat,
	output logic [p2n_pkg::RAW_W-1:0]    raw_note
);

	logic                          busy_q;
	logic                          done_q;
	logic [p2n_pkg::RAW_W-1:0]     bit_q;
	logic [p2n_pkg::RAW_W-1:0]     lo_q;
	logic [p2n_pkg::FREQ_W-1:0]    freq_q;

	logic [p2n_pkg::RAW_W-1:0]     probe;
	logic [8:0]                    m;
	logic [15:0]                   prod;
	logic [4:0]                    octave;
	logic [8:0]                    rem9;
	logic [5:0]                    shamt;
	logic [p2n_pkg::CMP_W-1:0]     lhs;
	logic [p2n_pkg::CMP_W-1:0]     rhs;
	logic                          ge;

	// boundary index m = k + 3 split into octave m/12 and semitone m%12
	always_comb begin
		probe  = lo_q | bit_q;
		m      = {1'b0, probe} + 9'd3;
		prod   = {7'd0, m} * 16'd171;
		octave = prod[15:11];
		rem9   = m - ({1'b0, octave, 3'b000} + {2'b00, octave, 2'b00});
		shamt  = {1'b0, octave} + 6'(p2n_pkg::FREQ_FRAC_BITS);
		lhs    = p2n_pkg::CMP_W'(freq_q) << p2n_pkg::LHS_SHIFT;
		rhs    = p2n_pkg::CMP_W'(p2n_pkg::edge_value(rem9[3:0])) << shamt;
		ge     = lhs >= rhs;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			bit_q  <= '0;
			lo_q   <= '0;
			freq_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				freq_q <= freq;
				lo_q   <= '0;
				bit_q  <= {1'b1, {(p2n_pkg::RAW_W-1){1'b0}}};
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (ge) begin
					lo_q <= probe;
				end
				bit_q <= bit_q >> 1;
				if (bit_q[0]) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign raw_note  = lo_q;

endmodule

>>> src/pitch_to_note_event_stabilizer.sv
// ----------------------------------------------------------------------------
// pitch_to_note_event_stabilizer - pitch reports in, note-off/note-on out
// Gates each report, maps its frequency to a note, holds the candidate for
// the configured number of reports and emits the resulting events.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake             | word
//  --------+-----------+-----------------------+-------------------------------
//  in      | input     | in_valid / in_ready   | in_data   (p2n_pkg::in_word_t)
//  out     | output    | out_valid / out_ready | out_data  (p2n_pkg::out_word_t)
//  cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
//  Sequence: one report occupies the block through the accept cycle, the
//  boundary compares in the search unit, its done cycle and the decide
//  cycle. Its events are loaded at the decide step and then leave at one
//  word a cycle while out_ready is high.
//  Reset: arst_n clears the sequencer, the event buffer and all note state;
//  registers return to their reset values.
//  Stalls: the next report is accepted while earlier events still wait;
//  the decide step holds until the event buffer is empty.
//  cfg_ready is always high.
//
module pitch_to_note_event_stabilizer (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  p2n_pkg::in_word_t                 in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output p2n_pkg::out_word_t                out_data,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [p2n_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [p2n_pkg::CFG_DATA_W-1:0]    cfg_data
);

	// configuration registers
	logic [12:0]                   gate_thr_q;
	logic [15:0]                   min_conf_q;
	logic [5:0]                    transpose_q;
	logic [p2n_pkg::VEL_W-1:0]     velocity_q;
	logic [3:0]                    hold_q;

	// note state
	logic                          act_valid_q;
	logic [p2n_pkg::NOTE_W-1:0]    act_note_q;
	logic                          cand_valid_q;
	logic [p2n_pkg::NOTE_W-1:0]    cand_note_q;
	logic [3:0]                    stable_cnt_q;
	logic                          gate_ok_q;

	// sequencer
	p2n_pkg::seq_state_t           state_q;
	p2n_pkg::seq_state_t           state_d;
	logic                          in_fire;
	logic                          decide_fire;

	// event buffer, slot 0 drives the output
	p2n_pkg::out_word_t            slot0_q;
	p2n_pkg::out_word_t            slot1_q;
	logic [1:0]                    out_cnt_q;

	// search unit
	p2n_pkg::srch_stat_t           srch_stat;
	logic [p2n_pkg::RAW_W-1:0]     raw_note;

	// decide path
	logic [9:0]                    note_sum;
	logic [p2n_pkg::NOTE_W-1:0]    next_note;
	logic                          next_valid;
	logic                          same;
	logic [3:0]                    cnt_new;
	logic                          cand_v_new;
	logic [p2n_pkg::NOTE_W-1:0]    cand_n_new;
	logic                          acc_valid;
	logic [p2n_pkg::NOTE_W-1:0]    acc_note;
	logic                          change;
	p2n_pkg::out_word_t            ev_off;
	p2n_pkg::out_word_t            ev_on;

	p2n_search u_search (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (in_fire),
		.freq     (in_data.pitch_frequency),
		.stat     (srch_stat),
		.raw_note (raw_note)
	);

	// ---------------------------------------------------------------- config
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gate_thr_q  <= 13'd786;
			min_conf_q  <= 16'd47186;
			transpose_q <= 6'd0;
			velocity_q  <= 7'd96;
			hold_q      <= 4'd3;
		end else if (cfg_valid) begin
			unique case (p2n_pkg::cfg_reg_t'(cfg_index))
				p2n_pkg::REG_GATE_THRESHOLD: gate_thr_q  <= cfg_data[12:0];
				p2n_pkg::REG_MIN_CONFIDENCE: min_conf_q  <= cfg_data;
				p2n_pkg::REG_TRANSPOSE:      transpose_q <= cfg_data[5:0];
				p2n_pkg::REG_NOTE_VELOCITY:  velocity_q  <= cfg_data[6:0];
				p2n_pkg::REG_HOLD_BLOCKS:    hold_q      <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------- sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= p2n_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		decide_fire = 1'b0;
		unique case (state_q)
			p2n_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = p2n_pkg::ST_SEARCH;
				end
			end
			p2n_pkg::ST_SEARCH: begin
				if (srch_stat.done) begin
					state_d = p2n_pkg::ST_DECIDE;
				end
			end
			p2n_pkg::ST_DECIDE: begin
				// hold until every event of the previous report has left
				if (out_cnt_q == 2'd0) begin
					decide_fire = 1'b1;
					state_d     = p2n_pkg::ST_IDLE;
				end
			end
			default: state_d = p2n_pkg::ST_IDLE;
		endcase
	end

	assign in_fire = in_valid && in_ready;

	// latch the gate decision with the report; the user must keep registers stable while busy (not enforced)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gate_ok_q <= 1'b0;
		end else if (in_fire) begin
			gate_ok_q <= in_data.pitch_found
				&& (in_data.signal_level >= {3'b000, gate_thr_q})
				&& (in_data.pitch_confidence >= min_conf_q);
		end
	end

	// ----------------------------------------------------------- decide path
	always_comb begin
		// raw note plus sign-extended transpose, clamped to the note range
		note_sum = {2'b00, raw_note} + {{4{transpose_q[5]}}, transpose_q};
		if (note_sum[9]) begin
			next_note = '0;
		end else if (note_sum[8:0] > 9'(p2n_pkg::MAX_NOTE)) begin
			next_note = p2n_pkg::NOTE_W'(p2n_pkg::MAX_NOTE);
		end else begin
			next_note = note_sum[6:0];
		end
		next_valid = gate_ok_q;
		if (!next_valid) begin
			next_note = '0;
		end

		// advance or restart the stability count
		same = (next_valid == cand_valid_q) && (!next_valid || next_note == cand_note_q);
		if (same) begin
			cnt_new    = (stable_cnt_q == 4'd15) ? 4'd15 : stable_cnt_q + 4'd1;
			cand_v_new = cand_valid_q;
			cand_n_new = cand_note_q;
		end else begin
			cnt_new    = 4'd1;
			cand_v_new = next_valid;
			cand_n_new = next_note;
		end

		if (cnt_new >= hold_q) begin
			acc_valid = cand_v_new;
			acc_note  = cand_n_new;
		end else begin
			acc_valid = act_valid_q;
			acc_note  = act_note_q;
		end
		change = (acc_valid != act_valid_q) || (acc_valid && acc_note != act_note_q);

		ev_off.event_kind     = p2n_pkg::EV_NOTE_OFF;
		ev_off.note_number    = act_note_q;
		ev_off.event_velocity = '0;
		ev_off.last_event     = !acc_valid;

		ev_on.event_kind      = p2n_pkg::EV_NOTE_ON;
		ev_on.note_number     = acc_note;
		ev_on.event_velocity  = velocity_q;
		ev_on.last_event      = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_valid_q  <= 1'b0;
			act_note_q   <= '0;
			cand_valid_q <= 1'b0;
			cand_note_q  <= '0;
			stable_cnt_q <= '0;
		end else if (decide_fire) begin
			cand_valid_q <= cand_v_new;
			cand_note_q  <= cand_n_new;
			stable_cnt_q <= cnt_new;
			if (change) begin
				act_valid_q <= acc_valid;
				act_note_q  <= acc_valid ? acc_note : '0;
			end
		end
	end

	// ---------------------------------------------------------- event buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_cnt_q <= 2'd0;
		end else if (decide_fire) begin
			// buffer is empty here: load off then on, off alone, or on alone
			if (change) begin
				out_cnt_q <= {1'b0, act_valid_q} + {1'b0, acc_valid};
			end
		end else if (out_valid && out_ready) begin
			out_cnt_q <= out_cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (decide_fire) begin
			if (act_valid_q) begin
				slot0_q <= ev_off;
				slot1_q <= ev_on;
			end else begin
				slot0_q <= ev_on;
				slot1_q <= ev_on;
			end
		end else if (out_valid && out_ready) begin
			// advance the second word into the output slot
			slot0_q <= slot1_q;
		end
	end

	assign out_valid = out_cnt_q != 2'd0;
	assign out_data  = slot0_q;

	// ------------------------------------------------------------ assertions
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_cnt_q != 2'd3)
		else $error("event buffer count out of range");

	a_on_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.event_kind == p2n_pkg::EV_NOTE_ON |-> out_data.last_event)
		else $error("note-on word not marked last");

	a_off_zero_vel: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.event_kind == p2n_pkg::EV_NOTE_OFF
			|-> out_data.event_velocity == '0)
		else $error("note-off word with nonzero velocity");

	a_done_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		srch_stat.done |-> state_q == p2n_pkg::ST_SEARCH)
		else $error("search finished outside the search state");

	a_silence_note: assert property (@(posedge clk) disable iff (!arst_n)
		!act_valid_q |-> act_note_q == '0)
		else $error("silent active note register not cleared");

endmodule
